// ===== rtl/core/jpeg_bit_writer_stuffing_macros.svh =====
// Assertion macros for the JPEG bit writer core.
// Used by the top level of the core, jpeg_bit_writer_stuffing.sv; needs nothing else.
`ifndef JPEG_BIT_WRITER_STUFFING_MACROS_SVH
`define JPEG_BIT_WRITER_STUFFING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JBW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jbw: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JBW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jbw: next-cycle check failed");

`endif

// ===== rtl/core/jbw_pkg.sv =====
// Package for the JPEG bit writer: command codes, constants and shared types.
// Depends on nothing; jbw_pack_unit, jbw_out_reg and the top level import it.
package jbw_pkg;

	localparam int JBW_MAX_CODE_BITS = 32;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_FLUSH = 2'd1;
	localparam logic [1:0] CMD_RAW   = 2'd2;

	localparam logic [7:0] MARKER_BYTE = 8'hFF;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} emit_t;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] fill_next;
		logic [3:0] take;
		logic       complete;
	} pack_t;

endpackage

// ===== rtl/core/jbw_if.sv =====
// Valid/ready channel interfaces of the JPEG bit writer: code items and stream bytes.
// Depends on nothing.
interface jbw_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] data_bits;
	logic [5:0]  bit_count;

	modport source (output valid, output command, output data_bits, output bit_count,
		input ready);
	modport sink (input valid, input command, input data_bits, input bit_count,
		output ready);
endinterface

interface jbw_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic [31:0] bytes_written;

	modport source (output valid, output out_byte, output last_of_run,
		output bytes_written, input ready);
	modport sink (input valid, input out_byte, input last_of_run, input bytes_written,
		output ready);
endinterface

// ===== rtl/core/jbw_pack_unit.sv =====
// Shift unit: merges up to one byte's worth of code bits into the pending bits.
// Depends on jbw_pkg.
module jbw_pack_unit
	import jbw_pkg::*;
#(
	parameter int REM_W = 6
) (
	input  logic [6:0]       acc,
	input  logic [2:0]       fill,
	input  logic [7:0]       top_bits,
	input  logic [REM_W-1:0] remaining,
	output pack_t            pack
);

	logic [3:0]  avail;
	logic [3:0]  take;
	logic [14:0] merged;

	always_comb begin
		avail = 4'd8 - {1'b0, fill};
		if (remaining < REM_W'(avail)) begin
			take = remaining[3:0];
		end else begin
			take = avail;
		end
		merged = {acc, top_bits} >> (4'd8 - take);
		pack.data = merged[7:0];
		pack.take = take;
		pack.complete = (({1'b0, fill} + take) == 4'd8);
		pack.fill_next = fill + take[2:0];
	end

endmodule

// ===== rtl/core/jbw_out_reg.sv =====
// Output register of the JPEG bit writer: holds one stream byte and the running byte count.
// Depends on jbw_pkg and jbw_if.
module jbw_out_reg
	import jbw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  emit_t            emit,
	output logic             slot_free,
	jbw_out_if.source        result
);

	logic        valid_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic [31:0] total_q;

	assign slot_free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			total_q <= '0;
		end else if (emit.valid) begin
			valid_q <= 1'b1;
			total_q <= total_q + 32'd1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			data_q <= emit.data;
			last_q <= emit.last;
		end
	end

	assign result.valid = valid_q;
	assign result.out_byte = data_q;
	assign result.last_of_run = last_q;
	assign result.bytes_written = total_q;

endmodule

// ===== rtl/core/jpeg_bit_writer_stuffing.sv =====
// Top level of the JPEG entropy bit writer with 0xFF byte stuffing.
// Depends on jbw_pkg, jbw_if, jbw_pack_unit, jbw_out_reg and the assertion macros.
//
// Channel | Dir | Fields                                   | Beat
// item    | in  | command, data_bits, bit_count            | valid & ready
// result  | out | out_byte, last_of_run, bytes_written     | valid & ready
//
// A put item is loaded, then merged into the pending bits in steps of up to 8 - pending
// bits each; a 32-bit code takes four to five steps, and a zero byte is stuffed after
// each 0xFF byte. Flush zero-pads the pending bits to a byte; raw emits its low byte.
// Reset clears the pending bits, the byte count and the sequencer at once.
// A stalled result holds the sequencer on the step that produces the next byte.
`include "jpeg_bit_writer_stuffing_macros.svh"

module jpeg_bit_writer_stuffing
	import jbw_pkg::*;
#(
	parameter int MAX_CODE_BITS = JBW_MAX_CODE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	jbw_in_if.sink    item,
	jbw_out_if.source result
);

	localparam int REM_W = $clog2(MAX_CODE_BITS + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_STEP  = 2'd1;
	localparam logic [1:0] S_STUFF = 2'd2;
	localparam logic [1:0] S_RAW   = 2'd3;

	logic [1:0]               state_q, state_d;
	logic [6:0]               acc_q, acc_d;
	logic [2:0]               fill_q, fill_d;
	logic [REM_W-1:0]         rem_q, rem_d;
	logic [MAX_CODE_BITS-1:0] data_q, data_d;

	logic [REM_W-1:0] rem_after;
	logic [5:0]       count_sat;
	logic [REM_W-1:0] count_load;
	logic             slot_free;
	emit_t            emit;
	pack_t            pack;

	jbw_pack_unit #(
		.REM_W(REM_W)
	) u_pack (
		.acc      (acc_q),
		.fill     (fill_q),
		.top_bits (data_q[MAX_CODE_BITS-1 -: 8]),
		.remaining(rem_q),
		.pack     (pack)
	);

	jbw_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.slot_free(slot_free),
		.result   (result)
	);

	assign item.ready = (state_q == S_IDLE);
	assign rem_after = rem_q - REM_W'(pack.take);
	assign count_sat = (item.bit_count > 6'(MAX_CODE_BITS)) ? 6'(MAX_CODE_BITS)
		: item.bit_count;
	assign count_load = REM_W'(count_sat);

	always_comb begin
		state_d = state_q;
		acc_d = acc_q;
		fill_d = fill_q;
		rem_d = rem_q;
		data_d = data_q;
		emit = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					unique case (item.command)
						CMD_PUT: begin
							if (count_load != '0) begin
								rem_d = count_load;
								data_d = item.data_bits[MAX_CODE_BITS-1:0]
									<< (REM_W'(MAX_CODE_BITS) - count_load);
								state_d = S_STEP;
							end
						end
						CMD_FLUSH: begin
							if (fill_q != 3'd0) begin
								rem_d = REM_W'(4'd8 - {1'b0, fill_q});
								data_d = '0;
								state_d = S_STEP;
							end
						end
						CMD_RAW: begin
							data_d = MAX_CODE_BITS'(item.data_bits[7:0]) << (MAX_CODE_BITS - 8);
							state_d = S_RAW;
						end
						default: begin
						end
					endcase
				end
			end
			S_STEP: begin
				if (pack.complete) begin
					if (slot_free) begin
						emit.valid = 1'b1;
						emit.data = pack.data;
						emit.last = (rem_after < REM_W'(8)) && (pack.data != MARKER_BYTE);
						acc_d = '0;
						fill_d = '0;
						rem_d = rem_after;
						data_d = data_q << pack.take;
						if (pack.data == MARKER_BYTE) begin
							state_d = S_STUFF;
						end else if (rem_after == '0) begin
							state_d = S_IDLE;
						end
					end
				end else begin
					acc_d = pack.data[6:0];
					fill_d = pack.fill_next;
					rem_d = rem_after;
					data_d = data_q << pack.take;
					state_d = S_IDLE;
				end
			end
			S_STUFF: begin
				if (slot_free) begin
					emit.valid = 1'b1;
					emit.data = 8'h00;
					emit.last = (rem_q < REM_W'(8));
					state_d = (rem_q == '0) ? S_IDLE : S_STEP;
				end
			end
			S_RAW: begin
				if (slot_free) begin
					emit.valid = 1'b1;
					emit.data = data_q[MAX_CODE_BITS-1 -: 8];
					emit.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q <= '0;
			fill_q <= '0;
			rem_q <= '0;
		end else begin
			state_q <= state_d;
			acc_q <= acc_d;
			fill_q <= fill_d;
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	`JBW_ASSERT_IMP(a_idle_no_work, clk, arst_n, state_q == S_IDLE, rem_q == '0)
	`JBW_ASSERT_IMP(a_stuff_after_marker, clk, arst_n, state_q == S_STUFF,
		result.valid && (result.out_byte == MARKER_BYTE))
	`JBW_ASSERT_NXT(a_last_ends_run, clk, arst_n, emit.valid && emit.last,
		(state_q == S_IDLE) || ((state_q == S_STEP) && !pack.complete))
	`JBW_ASSERT_IMP(a_no_overwrite, clk, arst_n, emit.valid, slot_free)

endmodule

// ===== tb/jpeg_bit_writer_stuffing_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the JPEG bit writer with 0xFF byte stuffing.
// Depends on jbw_pkg, the jbw_in_if and jbw_out_if interfaces and the top level.
// Every byte is predicted from an accepted code beat and checked against the stream in order.
module jpeg_bit_writer_stuffing_tb;
	import jbw_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [7:0] STUFF_BYTE = 8'h00;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last_of_run;
		logic [31:0] bytes_written;
	} stream_byte_t;

	logic clk;
	logic arst_n;

	jbw_in_if  item_ch ();
	jbw_out_if result_ch ();

	jpeg_bit_writer_stuffing u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	logic [6:0]   pend_bits = '0;
	int           pend_fill = 0;
	logic [31:0]  stream_total = '0;
	stream_byte_t expected_bytes[$];
	stream_byte_t head_byte;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int fail_count = 0;
	int items_sent = 0;
	int bytes_checked = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push_byte(input logic [7:0] value);
		stream_byte_t entry;
		stream_total++;
		entry.out_byte = value;
		entry.last_of_run = 1'b0;
		entry.bytes_written = stream_total;
		expected_bytes.push_back(entry);
	endtask

	task automatic push_stuffed(input logic [7:0] value);
		push_byte(value);
		if (value == MARKER_BYTE)
			push_byte(STUFF_BYTE);
	endtask

	task automatic predict_item(input logic [1:0] cmd, input logic [31:0] data,
		input logic [5:0] count);
		int n;
		int first;
		logic [7:0] grown;
		stream_byte_t tail;
		first = expected_bytes.size();
		case (cmd)
			CMD_PUT: begin
				n = (count > JBW_MAX_CODE_BITS) ? JBW_MAX_CODE_BITS : count;
				for (int i = n - 1; i >= 0; i--) begin
					grown = {pend_bits, data[i]};
					if (pend_fill == 7) begin
						push_stuffed(grown);
						pend_bits = '0;
						pend_fill = 0;
					end else begin
						pend_bits = grown[6:0];
						pend_fill++;
					end
				end
			end
			CMD_FLUSH: begin
				if (pend_fill > 0) begin
					grown = {1'b0, pend_bits} << (8 - pend_fill);
					pend_bits = '0;
					pend_fill = 0;
					push_stuffed(grown);
				end
			end
			CMD_RAW: begin
				push_byte(data[7:0]);
			end
			default: begin
			end
		endcase
		if (expected_bytes.size() > first) begin
			tail = expected_bytes.pop_back();
			tail.last_of_run = 1'b1;
			expected_bytes.push_back(tail);
		end
	endtask

	// Returns right after the beat, with valid still high.
	task automatic send_item(input logic [1:0] cmd, input logic [31:0] data,
		input logic [5:0] count);
		@(negedge clk);
		while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.data_bits <= data;
		item_ch.bit_count <= count;
		do
			@(posedge clk);
		while (!item_ch.ready);
		predict_item(cmd, data, count);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] dense_word();
		return $urandom | $urandom | $urandom;
	endfunction

	task automatic test_directed();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		send_item(CMD_PUT, 32'h0000_00A5, 6'd8);
		send_item(CMD_PUT, 32'hFFFF_FFFF, 6'd0);
		send_item(CMD_PUT, 32'hFFFF_FFFF, 6'd32);
		send_item(CMD_PUT, 32'h1234_5678, 6'd63);
		send_item(CMD_PUT, 32'h0000_0005, 6'd3);
		send_item(CMD_FLUSH, 32'hFFFF_FFFF, 6'd63);
		send_item(CMD_FLUSH, 32'h0000_0000, 6'd0);
		send_item(CMD_RAW, 32'h0000_00FF, 6'd0);
		send_item(CMD_PUT, 32'h0000_001F, 6'd5);
		send_item(CMD_RAW, 32'hFFFF_FF3C, 6'd8);
		send_item(CMD_PUT, 32'h0000_0007, 6'd3);
		send_item(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63);
		send_item(CMD_PUT, 32'h0000_007F, 6'd7);
		send_item(CMD_PUT, 32'h0000_0001, 6'd1);
		send_item(CMD_PUT, 32'h0000_0000, 6'd32);
		send_item(CMD_PUT, 32'h8000_0001, 6'd33);
		send_item(CMD_PUT, 32'h0000_0003, 6'd2);
		send_item(CMD_FLUSH, 32'h0000_0000, 6'd0);
		send_item(CMD_PUT, 32'h0000_007F, 6'd7);
		send_item(CMD_FLUSH, 32'h0000_0000, 6'd0);
		send_item(CMD_RAW, 32'h0000_0000, 6'd0);
		send_item(CMD_PUT, 32'hAAAA_AAAA, 6'd31);
		send_item(CMD_FLUSH, 32'h0000_0000, 6'd0);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
		logic [1:0] cmd;
		logic [31:0] data;
		logic [5:0] bits;
		int sel;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			case ($urandom_range(7))
				0, 1, 2: data = dense_word();
				3: data = '1;
				default: data = $urandom;
			endcase
			cmd = CMD_PUT;
			bits = $urandom_range(1, 12);
			if (sel >= 55 && sel < 70)
				bits = $urandom_range(0, 63);
			else if (sel >= 70 && sel < 82)
				cmd = CMD_FLUSH;
			else if (sel >= 82 && sel < 96)
				cmd = CMD_RAW;
			else if (sel >= 96)
				cmd = CMD_UNUSED;
			if (cmd != CMD_PUT)
				bits = $urandom_range(0, 63);
			send_item(cmd, data, bits);
		end
		wait_drained();
	endtask

	task automatic test_fill_stall();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_left = HOLD_CYCLES;
		for (int k = 0; k < 40; k++)
			send_item(CMD_PUT, dense_word(), 6'd32);
		wait_drained();
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected byte %h last %b count %0d", $time,
					result_ch.out_byte, result_ch.last_of_run, result_ch.bytes_written);
			end else begin
				head_byte = expected_bytes.pop_front();
				bytes_checked++;
				if (result_ch.out_byte !== head_byte.out_byte
					|| result_ch.last_of_run !== head_byte.last_of_run
					|| result_ch.bytes_written !== head_byte.bytes_written) begin
					fail_count++;
					$display("%0t: expected byte %h last %b count %0d, got byte %h last %b count %0d",
						$time, head_byte.out_byte, head_byte.last_of_run,
						head_byte.bytes_written, result_ch.out_byte,
						result_ch.last_of_run, result_ch.bytes_written);
				end
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_ch.valid && item_ch.ready)
				|| (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no beat for %0d cycles, %0d bytes still expected", $time,
			QUIET_LIMIT, expected_bytes.size());
		$display("** jpeg_bit_writer_stuffing: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_PUT;
		item_ch.data_bits = '0;
		item_ch.bit_count = '0;
		result_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(140, 37, 47);
		test_random_traffic(140, 47, 37);
		test_fill_stall();
		test_random_traffic(130, 0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d code beats and checked %0d stream bytes over directed, random,",
			items_sent, bytes_checked);
		$display("output hold-off and drain phases, with stuffing and zero-pad flushes.");
		if (fail_count == 0 && expected_bytes.size() == 0)
			$display("** jpeg_bit_writer_stuffing: PASSED **");
		else
			$display("** jpeg_bit_writer_stuffing: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/jbw_pkg.sv
rtl/core/jbw_if.sv
rtl/core/jbw_pack_unit.sv
rtl/core/jbw_out_reg.sv
rtl/core/jpeg_bit_writer_stuffing.sv
tb/jpeg_bit_writer_stuffing_tb.sv
